/* hw/rtl/smsp_pkg.sv */
// ----------------------------------------------------------------------------
// Symbolic mode parser package
// Shared types and character and mask constants for the symbolic mode parser.
// ----------------------------------------------------------------------------
package smsp_pkg;

   localparam int ModeWidth  = 12;
   localparam int OldWidth   = 16;
   localparam int UmaskWidth = 9;

   localparam logic [UmaskWidth-1:0] UMASK_RESET = 9'o022;

   localparam logic [1:0] PH_WHO   = 2'd0;
   localparam logic [1:0] PH_PERM  = 2'd1;
   localparam logic [1:0] PH_AFTER = 2'd2;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_SET = 2'd2;

   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_BIG_X = 8'h58;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   localparam logic [ModeWidth-1:0] WHO_ALL   = 12'o7777;
   localparam logic [ModeWidth-1:0] WHO_USER  = 12'o4700;
   localparam logic [ModeWidth-1:0] WHO_GROUP = 12'o2070;
   localparam logic [ModeWidth-1:0] WHO_OTHER = 12'o0007;
   localparam logic [ModeWidth-1:0] PERM_R    = 12'o0444;
   localparam logic [ModeWidth-1:0] PERM_W    = 12'o0222;
   localparam logic [ModeWidth-1:0] PERM_X    = 12'o0111;
   localparam logic [ModeWidth-1:0] PERM_S    = 12'o6000;
   localparam logic [ModeWidth-1:0] PERM_T    = 12'o1000;

   localparam logic [3:0] TYPE_DIR = 4'o04;

   typedef struct packed {
      logic [1:0]           phase;
      logic [ModeWidth-1:0] who_bits;
      logic                 who_seen;
      logic [1:0]           action_kind;
      logic [ModeWidth-1:0] perm_mask;
      logic [ModeWidth-1:0] mode_acc;
      logic [OldWidth-1:0]  orig_mode;
      logic                 error_flag;
   } state_type;

   typedef struct packed {
      logic [7:0]          ch;
      logic                first;
      logic                last;
      logic                empty_req;
      logic [OldWidth-1:0] old_mode;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic [ModeWidth-1:0] new_mode;
      logic                 error;
   } result_type;

endpackage

/* hw/rtl/smsp_step.sv */
// ----------------------------------------------------------------------------
// Symbolic mode parser step
// Next parse state and result for one character item.
// ----------------------------------------------------------------------------
module smsp_step (
   input  smsp_pkg::state_type              cur,
   input  smsp_pkg::item_type               item,
   input  logic [smsp_pkg::UmaskWidth-1:0]  umask,
   output smsp_pkg::state_type              nxt,
   output smsp_pkg::result_type             res
);
   import smsp_pkg::*;

   function automatic logic [ModeWidth-1:0] apply_action(
      input state_type                s,
      input logic [UmaskWidth-1:0]    um
   );
      logic [ModeWidth-1:0] md;
      logic [ModeWidth-1:0] um_w;
      logic                 has_who;
      md      = s.mode_acc;
      um_w    = {3'b000, um};
      has_who = (s.who_bits != '0);
      if (s.action_kind == ACT_SET) begin
         md = has_who ? (md & ~s.who_bits) : '0;
      end
      if (s.action_kind == ACT_SET || s.action_kind == ACT_ADD) begin
         md = has_who ? (md | (s.who_bits & s.perm_mask)) : (md | (s.perm_mask & ~um_w));
      end else if (s.action_kind == ACT_SUB) begin
         md = has_who ? (md & ~(s.who_bits & s.perm_mask)) : (md & (~s.perm_mask | um_w));
      end
      return md;
   endfunction

   function automatic state_type start_or_error(input state_type s, input logic [7:0] c);
      state_type r;
      r = s;
      case (c)
         CH_PLUS: begin
            r.action_kind = ACT_ADD;
            r.perm_mask   = '0;
            r.phase       = PH_PERM;
         end
         CH_MINUS: begin
            r.action_kind = ACT_SUB;
            r.perm_mask   = '0;
            r.phase       = PH_PERM;
         end
         CH_EQUAL: begin
            r.action_kind = ACT_SET;
            r.perm_mask   = '0;
            r.phase       = PH_PERM;
         end
         default: begin
            r.error_flag = 1'b1;
         end
      endcase
      return r;
   endfunction

   function automatic state_type after_char(input state_type s, input logic [7:0] c);
      state_type r;
      r = s;
      if (c == CH_COMMA) begin
         r.phase    = PH_WHO;
         r.who_bits = '0;
         r.who_seen = 1'b0;
      end else begin
         r = start_or_error(s, c);
      end
      return r;
   endfunction

   state_type            s;
   logic [2:0]           cls;
   logic                 x_ok;

   always_comb begin
      s   = cur;
      cls = 3'b000;
      if (item.first) begin
         s.orig_mode   = item.old_mode;
         s.mode_acc    = item.old_mode[ModeWidth-1:0];
         s.phase       = PH_WHO;
         s.who_bits    = '0;
         s.who_seen    = 1'b0;
         s.action_kind = ACT_ADD;
         s.perm_mask   = '0;
         s.error_flag  = 1'b0;
      end
      x_ok = (s.orig_mode[15:12] == TYPE_DIR) || ((s.orig_mode[ModeWidth-1:0] & PERM_X) != '0);
      if (!item.empty_req && !s.error_flag) begin
         case (s.phase)
            PH_WHO: begin
               case (item.ch)
                  CH_A: begin
                     s.who_bits = s.who_bits | WHO_ALL;
                     s.who_seen = 1'b1;
                  end
                  CH_U: begin
                     s.who_bits = s.who_bits | WHO_USER;
                     s.who_seen = 1'b1;
                  end
                  CH_G: begin
                     s.who_bits = s.who_bits | WHO_GROUP;
                     s.who_seen = 1'b1;
                  end
                  CH_O: begin
                     s.who_bits = s.who_bits | WHO_OTHER;
                     s.who_seen = 1'b1;
                  end
                  default: begin
                     s = start_or_error(s, item.ch);
                  end
               endcase
            end
            PH_PERM: begin
               case (item.ch)
                  CH_R: s.perm_mask = s.perm_mask | PERM_R;
                  CH_W: s.perm_mask = s.perm_mask | PERM_W;
                  CH_X: s.perm_mask = s.perm_mask | PERM_X;
                  CH_S: s.perm_mask = s.perm_mask | PERM_S;
                  CH_T: begin
                     s.perm_mask = s.perm_mask | PERM_T;
                     s.who_bits  = s.who_bits | PERM_T;
                  end
                  CH_BIG_X: begin
                     if (x_ok) begin
                        s.perm_mask = s.perm_mask | PERM_X;
                     end
                  end
                  CH_U, CH_G, CH_O: begin
                     if (item.ch == CH_U) begin
                        cls = s.mode_acc[8:6];
                     end else if (item.ch == CH_G) begin
                        cls = s.mode_acc[5:3];
                     end else begin
                        cls = s.mode_acc[2:0];
                     end
                     s.perm_mask = s.perm_mask | {3'b000, cls, cls, cls};
                     s.mode_acc  = apply_action(s, umask);
                     s.phase     = PH_AFTER;
                  end
                  default: begin
                     s.mode_acc = apply_action(s, umask);
                     s.phase    = PH_AFTER;
                     s          = after_char(s, item.ch);
                  end
               endcase
            end
            PH_AFTER: begin
               s = after_char(s, item.ch);
            end
            default: begin
               s.error_flag = 1'b1;
            end
         endcase
      end

      res.valid    = item.last;
      res.new_mode = '0;
      res.error    = 1'b0;
      if (item.last) begin
         if (!s.error_flag) begin
            if (s.phase == PH_PERM) begin
               s.mode_acc = apply_action(s, umask);
               s.phase    = PH_AFTER;
            end else if (s.phase == PH_WHO && s.who_seen) begin
               s.error_flag = 1'b1;
            end
         end
         res.new_mode  = s.error_flag ? '0 : s.mode_acc;
         res.error     = s.error_flag;
         s.phase       = PH_WHO;
         s.who_bits    = '0;
         s.who_seen    = 1'b0;
         s.action_kind = ACT_ADD;
         s.perm_mask   = '0;
         s.error_flag  = 1'b0;
      end
      nxt = s;
   end

endmodule

/* hw/rtl/smsp_rsp_reg.sv */
// ----------------------------------------------------------------------------
// Symbolic mode parser result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module smsp_rsp_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  smsp_pkg::result_type                 res,
   input  logic                                 rsp_stall,
   output logic                                 free,
   output logic                                 rsp_valid,
   output logic [smsp_pkg::ModeWidth-1:0]       rsp_new_mode,
   output logic                                 rsp_error
);
   import smsp_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [ModeWidth-1:0] mode_ff;
   logic                 error_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         mode_ff  <= res.new_mode;
         error_ff <= res.error;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_new_mode = mode_ff;
   assign rsp_error    = error_ff;

endmodule

/* hw/rtl/symbolic_mode_string_parser_top.sv */
// ----------------------------------------------------------------------------
// Symbolic mode string parser
// Parses a chmod-style symbolic mode string, one character per item, and
// gives the new 12-bit mode and an error flag at the end of each string.
//
// The req_ channel carries one character per item together with first, last
// and empty_req marks; old_mode is taken on the item marked first. An item
// marked last causes one rsp_ item, which is loaded into the result register
// when the item leaves the input register. One item is accepted every cycle
// while req_stall is low: the parse state is updated by a single step of
// mask logic between the input register and the result register. When the
// receiver stalls, a final character waits in the input register and
// req_stall rises only while that register is full and cannot move on;
// other characters keep flowing. The csr_ port writes the umask, which
// should change only while idle. Reset clears the parse state and both
// valid flags, sets the umask to octal 022 and leaves the result mode as is.
// ----------------------------------------------------------------------------
module symbolic_mode_string_parser_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_ch,
   input  logic                                 req_first,
   input  logic                                 req_last,
   input  logic                                 req_empty_req,
   input  logic [smsp_pkg::OldWidth-1:0]        req_old_mode,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [smsp_pkg::ModeWidth-1:0]       rsp_new_mode,
   output logic                                 rsp_error,
   input  logic                                 csr_wr_en,
   input  logic [smsp_pkg::UmaskWidth-1:0]      csr_wr_data
);
   import smsp_pkg::*;

   logic                  in_valid_ff;
   item_type              item_ff;
   state_type             state_ff;
   state_type             state_in;
   result_type            res;
   logic [UmaskWidth-1:0] umask_ff;
   logic                  out_free;
   logic                  consume;

   assign consume   = in_valid_ff && (!item_ff.last || out_free);
   assign req_stall = in_valid_ff && !consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.ch        <= req_ch;
         item_ff.first     <= req_first;
         item_ff.last      <= req_last;
         item_ff.empty_req <= req_empty_req;
         item_ff.old_mode  <= req_old_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         umask_ff <= UMASK_RESET;
      end else if (csr_wr_en) begin
         umask_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (consume) begin
         state_ff <= state_in;
      end
   end

   smsp_step u_step (
      .cur   (state_ff),
      .item  (item_ff),
      .umask (umask_ff),
      .nxt   (state_in),
      .res   (res)
   );

   smsp_rsp_reg u_rsp (
      .clock        (clock),
      .reset        (reset),
      .load         (consume && res.valid),
      .res          (res),
      .rsp_stall    (rsp_stall),
      .free         (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_new_mode (rsp_new_mode),
      .rsp_error    (rsp_error)
   );

endmodule

/* verif/symbolic_mode_string_parser_top_tb.sv */
// ----------------------------------------------------------------------------
// Symbolic mode string parser testbench
// Sends chmod-style symbolic mode strings one character per item and checks
// each resulting mode and error flag against a mode predictor kept inside
// the bench. Directed strings cover every class, action, permission letter,
// copy letter and several malformed forms. Random strings, mostly well formed
// with some noise, then run under three idling patterns and several umask values.
// ----------------------------------------------------------------------------
module symbolic_mode_string_parser_top_tb;
   import smsp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 6;

   localparam logic [4*8-1:0] WHO_CHARS    = {CH_A, CH_U, CH_G, CH_O};
   localparam logic [6*8-1:0] PERM_CHARS   = {CH_R, CH_W, CH_X, CH_S, CH_T, CH_BIG_X};
   localparam logic [3*8-1:0] ACTION_CHARS = {CH_PLUS, CH_MINUS, CH_EQUAL};
   localparam logic [3*8-1:0] COPY_CHARS   = {CH_U, CH_G, CH_O};

   typedef struct packed {
      logic [ModeWidth-1:0] new_mode;
      logic                 error;
   } mode_result_type;

   typedef logic [7:0] char_q_type [$];

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_ch        = '0;
   logic                  req_first     = 1'b0;
   logic                  req_last      = 1'b0;
   logic                  req_empty_req = 1'b0;
   logic [OldWidth-1:0]   req_old_mode  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [ModeWidth-1:0]  rsp_new_mode;
   logic                  rsp_error;
   logic                  csr_wr_en     = 1'b0;
   logic [UmaskWidth-1:0] csr_wr_data   = '0;

   logic [1:0]            ps_phase    = PH_WHO;
   logic [ModeWidth-1:0]  ps_who      = '0;
   logic                  ps_who_seen = 1'b0;
   logic [1:0]            ps_action   = ACT_ADD;
   logic [ModeWidth-1:0]  ps_perm     = '0;
   logic [ModeWidth-1:0]  ps_mode     = '0;
   logic [OldWidth-1:0]   ps_orig     = '0;
   logic                  ps_error    = 1'b0;
   logic [UmaskWidth-1:0] umask_now   = UMASK_RESET;

   mode_result_type expected_modes [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int fail_count    = 0;

   symbolic_mode_string_parser_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_first     (req_first),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .req_old_mode  (req_old_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_new_mode  (rsp_new_mode),
      .rsp_error     (rsp_error),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic clear_clause_state();
      ps_phase    = PH_WHO;
      ps_who      = '0;
      ps_who_seen = 1'b0;
      ps_action   = ACT_ADD;
      ps_perm     = '0;
      ps_error    = 1'b0;
   endtask

   task automatic open_action(input logic [7:0] ch, output bit ok);
      ok = 1'b1;
      case (ch)
         CH_PLUS:  ps_action = ACT_ADD;
         CH_MINUS: ps_action = ACT_SUB;
         CH_EQUAL: ps_action = ACT_SET;
         default:  ok = 1'b0;
      endcase
      if (ok) begin
         ps_perm  = '0;
         ps_phase = PH_PERM;
      end
   endtask

   task automatic commit_action();
      logic [ModeWidth-1:0] um;
      um = {3'b000, umask_now};
      if (ps_action == ACT_SET) begin
         if (ps_who != '0) ps_mode = ps_mode & ~ps_who;
         else ps_mode = '0;
      end
      if (ps_action == ACT_SET || ps_action == ACT_ADD) begin
         if (ps_who != '0) ps_mode = ps_mode | (ps_who & ps_perm);
         else ps_mode = ps_mode | (ps_perm & ~um);
      end else if (ps_action == ACT_SUB) begin
         if (ps_who != '0) ps_mode = ps_mode & ~(ps_who & ps_perm);
         else ps_mode = ps_mode & (~ps_perm | um);
      end
   endtask

   task automatic after_action_char(input logic [7:0] ch);
      bit ok;
      if (ch == CH_COMMA) begin
         ps_phase    = PH_WHO;
         ps_who      = '0;
         ps_who_seen = 1'b0;
      end else begin
         open_action(ch, ok);
         if (!ok) ps_error = 1'b1;
      end
   endtask

   task automatic parse_char(input logic [7:0] ch);
      bit                   ok;
      logic [ModeWidth-1:0] t;
      case (ps_phase)
         PH_WHO: begin
            case (ch)
               CH_A: begin
                  ps_who      = ps_who | WHO_ALL;
                  ps_who_seen = 1'b1;
               end
               CH_U: begin
                  ps_who      = ps_who | WHO_USER;
                  ps_who_seen = 1'b1;
               end
               CH_G: begin
                  ps_who      = ps_who | WHO_GROUP;
                  ps_who_seen = 1'b1;
               end
               CH_O: begin
                  ps_who      = ps_who | WHO_OTHER;
                  ps_who_seen = 1'b1;
               end
               default: begin
                  open_action(ch, ok);
                  if (!ok) ps_error = 1'b1;
               end
            endcase
         end
         PH_PERM: begin
            case (ch)
               CH_R: ps_perm = ps_perm | PERM_R;
               CH_W: ps_perm = ps_perm | PERM_W;
               CH_X: ps_perm = ps_perm | PERM_X;
               CH_S: ps_perm = ps_perm | PERM_S;
               CH_T: begin
                  ps_perm = ps_perm | PERM_T;
                  ps_who  = ps_who | PERM_T;
               end
               CH_BIG_X: begin
                  if (ps_orig[15:12] == TYPE_DIR || (ps_orig[8:0] & 9'o111) != '0)
                     ps_perm = ps_perm | PERM_X;
               end
               CH_U: begin
                  t        = ps_mode & 12'o0700;
                  ps_perm  = ps_perm | t | (t >> 3) | (t >> 6);
                  commit_action();
                  ps_phase = PH_AFTER;
               end
               CH_G: begin
                  t        = ps_mode & 12'o0070;
                  ps_perm  = ps_perm | t | (t >> 3) | (t << 3);
                  commit_action();
                  ps_phase = PH_AFTER;
               end
               CH_O: begin
                  t        = ps_mode & 12'o0007;
                  ps_perm  = ps_perm | t | (t << 3) | (t << 6);
                  commit_action();
                  ps_phase = PH_AFTER;
               end
               default: begin
                  commit_action();
                  ps_phase = PH_AFTER;
                  after_action_char(ch);
               end
            endcase
         end
         PH_AFTER: after_action_char(ch);
         default:  ps_error = 1'b1;
      endcase
   endtask

   task automatic predict_mode(input logic [7:0] ch, input logic first, input logic last,
                               input logic empty, input logic [OldWidth-1:0] old);
      mode_result_type r;
      if (first) begin
         ps_orig = old;
         ps_mode = old[ModeWidth-1:0];
         clear_clause_state();
      end
      if (!empty && !ps_error) parse_char(ch);
      if (last) begin
         if (!ps_error) begin
            if (ps_phase == PH_PERM) begin
               commit_action();
               ps_phase = PH_AFTER;
            end else if (ps_phase == PH_WHO && ps_who_seen) begin
               ps_error = 1'b1;
            end
         end
         r.new_mode = ps_error ? '0 : ps_mode;
         r.error    = ps_error;
         expected_modes.push_back(r);
         clear_clause_state();
      end
   endtask

   task automatic send_item(input logic [7:0] ch, input logic first, input logic last,
                            input logic empty, input logic [OldWidth-1:0] old);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_ch        = ch;
      req_first     = first;
      req_last      = last;
      req_empty_req = empty;
      req_old_mode  = old;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_mode(ch, first, last, empty, old);
      if (!empty) items_sent++;
   endtask

   task automatic send_chars(input char_q_type chars, input logic [OldWidth-1:0] old,
                             input bit with_first, input int empty_pct);
      bit mark;
      mark = with_first;
      if (chars.size() == 0) begin
         send_item(8'($urandom), mark, 1'b1, 1'b1, old);
      end else begin
         for (int i = 0; i < chars.size(); i++) begin
            if ($urandom_range(0, 99) < empty_pct) begin
               send_item(8'($urandom), mark, 1'b0, 1'b1, mark ? old : 16'($urandom));
               mark = 1'b0;
            end
            send_item(chars[i], mark, i == chars.size() - 1, 1'b0,
                      mark ? old : 16'($urandom));
            mark = 1'b0;
         end
      end
   endtask

   task automatic send_text(input string text, input logic [OldWidth-1:0] old,
                            input bit with_first);
      char_q_type chars;
      for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
      send_chars(chars, old, with_first, 0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_modes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_umask(input logic [UmaskWidth-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      umask_now = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic test_wellformed_clauses();
      send_text("", 16'hffff, 1'b1);
      send_item(CH_PLUS, 1'b1, 1'b0, 1'b0, 16'o040600);
      send_item(8'hff, 1'b0, 1'b0, 1'b1, 16'h0000);
      send_item(CH_BIG_X, 1'b0, 1'b1, 1'b0, 16'hffff);
      send_text("go=u", 16'o000754, 1'b1);
      send_text("u=g-o", 16'o107531, 1'b1);
      send_text("a+rst", 16'h0000, 1'b1);
      send_text("-w,", 16'o000777, 1'b1);
      send_text("+x", 16'hffff, 1'b0);
   endtask

   task automatic test_malformed_clauses();
      char_q_type chars;
      send_text(",", 16'o000644, 1'b1);
      send_text("u,", 16'o000644, 1'b1);
      send_text("g", 16'o000644, 1'b1);
      chars.push_back(CH_O);
      chars.push_back(8'h00);
      chars.push_back(CH_PLUS);
      send_chars(chars, 16'o100755, 1'b1, 0);
      chars.delete();
      chars.push_back(CH_EQUAL);
      chars.push_back(CH_R);
      chars.push_back(8'hff);
      send_chars(chars, 16'o040777, 1'b1, 0);
   endtask

   task automatic test_random_traffic(input int target, input int idle_pct,
                                      input int stall_percent);
      char_q_type          chars;
      int                  clauses;
      int                  n;
      int                  m;
      logic [OldWidth-1:0] old;
      bit                  with_first;
      send_idle_pct = idle_pct;
      stall_pct     = stall_percent;
      items_sent    = 0;
      while (items_sent < target) begin
         chars.delete();
         clauses = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
         for (int c = 0; c < clauses; c++) begin
            if (c > 0) chars.push_back(CH_COMMA);
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) chars.push_back(WHO_CHARS[8*$urandom_range(0, 3) +: 8]);
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++) begin
               chars.push_back(ACTION_CHARS[8*$urandom_range(0, 2) +: 8]);
               if ($urandom_range(0, 4) == 0) begin
                  chars.push_back(COPY_CHARS[8*$urandom_range(0, 2) +: 8]);
               end else begin
                  m = $urandom_range(0, 3);
                  for (int j = 0; j < m; j++)
                     chars.push_back(PERM_CHARS[8*$urandom_range(0, 5) +: 8]);
               end
            end
         end
         if (clauses > 0 && $urandom_range(0, 9) == 0) chars.push_back(CH_COMMA);
         case ($urandom_range(0, 19))
            0: begin
               if (chars.size() != 0) chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom);
            end
            1: chars.push_back(8'($urandom));
            2: chars.push_front(CH_COMMA);
            3: chars.push_back(WHO_CHARS[8*$urandom_range(0, 3) +: 8]);
            default: ;
         endcase
         old = 16'($urandom);
         if ($urandom_range(0, 2) == 0) old[15:12] = TYPE_DIR;
         with_first = ($urandom_range(0, 19) != 0);
         send_chars(chars, old, with_first, 5);
         if ($urandom_range(0, 39) == 0) wait_drained();
      end
   endtask

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      mode_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_modes.size() == 0) begin
            $error("unexpected result item: new_mode %0o error %0b", rsp_new_mode, rsp_error);
            fail_count++;
         end else begin
            want = expected_modes.pop_front();
            if (rsp_new_mode !== want.new_mode) begin
               $error("new_mode: expected %0o, got %0o", want.new_mode, rsp_new_mode);
               fail_count++;
            end
            if (rsp_error !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_error);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_wellformed_clauses();
      write_umask(9'o077);
      test_malformed_clauses();
      write_umask(9'o000);
      test_random_traffic(250, 38, 64);
      write_umask(9'o777);
      test_random_traffic(250, 64, 38);
      write_umask(9'($urandom));
      test_random_traffic(250, 0, 0);
      wait_drained();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
